// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL; all are clocked on i_clk and
// switched off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/bnfa_pkg.sv =====
package bnfa_pkg;

    // Storage geometry
    localparam int NUM_WORDS  = 64;
    localparam int WORD_BITS  = 64;
    localparam int WORD_AW    = $clog2(NUM_WORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int OFF_W      = WORD_AW + BIT_W;
    localparam int CNT_W      = $clog2(NUM_WORDS + 1);
    localparam int CAPACITY   = NUM_WORDS * WORD_BITS;

    // Two-level lowest-bit search: groups of eight bits
    localparam int GROUP_BITS = 8;
    localparam int GROUP_IW   = $clog2(GROUP_BITS);
    localparam int GROUPS     = WORD_BITS / GROUP_BITS;
    localparam int GRP_W      = BIT_W - GROUP_IW;

    // Field and port widths
    localparam int IDX_W      = 16;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    localparam logic [IDX_W-1:0] RESET_LOWEST  = 16'd0;
    localparam logic [IDX_W-1:0] RESET_HIGHEST = 16'd4095;
    localparam logic [IDX_W-1:0] LAST_CAP_OFF  = IDX_W'(CAPACITY - 1);

    // Register indexes (paddr[2])
    localparam logic REG_LOWEST  = 1'b0;
    localparam logic REG_HIGHEST = 1'b1;

    typedef logic [1:0] t_opcode;
    localparam t_opcode OP_GET   = 2'd0;
    localparam t_opcode OP_SET   = 2'd1;
    localparam t_opcode OP_CLEAR = 2'd2;
    localparam t_opcode OP_FIND  = 2'd3;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK,
        S_MOD,
        S_SCAN,
        S_ACC,
        S_RESP
    } t_state;

    // Position of the lowest set bit; zero when none is set
    function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] vec);
        logic [GRP_W-1:0]      grp;
        logic [GROUP_IW-1:0]   pos;
        logic [GROUP_BITS-1:0] sel;
        grp = '0;
        for (int k = GROUPS - 1; k >= 0; k--) begin
            if (|vec[k*GROUP_BITS +: GROUP_BITS]) grp = GRP_W'(k);
        end
        sel = vec[grp*GROUP_BITS +: GROUP_BITS];
        pos = '0;
        for (int k = GROUP_BITS - 1; k >= 0; k--) begin
            if (sel[k]) pos = GROUP_IW'(k);
        end
        return {grp, pos};
    endfunction

endpackage

// ===== src/bitmap_next_free_allocator_core.sv =====
// Bitmap next-fit allocator.
// Input channel (i_in_valid / o_in_ready) carries one item: an opcode (get,
// set, clear, find next clear index) and an index. Output channel
// (o_out_valid / i_out_ready) returns one result item per input item:
// bit_value, found_index and status (ok, out of range, full).
// The bounds lowest_index / highest_index sit on an APB-style port at byte
// addresses 0 and 4; pready is tied high, writes land in the access cycle.
// Timing: the block takes one item at a time, o_in_ready is high only when
// the sequencer is idle. Get, set and clear go through a range check, a word
// read from the bitmap RAM and the result register, in that order.
// Find first takes R subtract steps, R in 0..NUM_WORDS-1, that fold the
// cursor back below W, the number of words in use, after a bound change;
// then the scan evaluates one RAM word per cycle, up to W words.
// Reset clears the cursor, restores the bounds and marks every word as
// zero through per-word valid flags, so the block is ready at once.
// A result waits in the output register while i_out_ready is low; the next
// item is still taken and is held back only when its own result is ready.
`include "assert_macros.svh"

module bitmap_next_free_allocator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // item in
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  bnfa_pkg::t_opcode              i_opcode,
    input  logic [bnfa_pkg::IDX_W-1:0]     i_index,
    // item out
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_bit_value,
    output logic [bnfa_pkg::IDX_W-1:0]     o_found_index,
    output bnfa_pkg::t_status              o_status,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [bnfa_pkg::CFG_AW-1:0]    paddr,
    input  logic [bnfa_pkg::CFG_DW-1:0]    pwdata,
    output logic [bnfa_pkg::CFG_DW-1:0]    prdata,
    output logic                           pready
);
    import bnfa_pkg::*;

    t_state                 r_state, n_state;
    logic [IDX_W-1:0]       r_lo, r_hi;
    t_opcode                r_op;
    logic [IDX_W-1:0]       r_index;
    logic [WORD_AW-1:0]     r_cursor;
    logic [WORD_AW-1:0]     r_addr;
    logic [WORD_AW-1:0]     r_pw;
    logic                   r_pend;
    logic [CNT_W-1:0]       r_words;
    logic [CNT_W-1:0]       r_left;
    logic [WORD_AW-1:0]     r_lastw;
    logic [WORD_BITS-1:0]   r_lmask;
    logic [WORD_AW-1:0]     r_wa;
    logic [BIT_W-1:0]       r_bitpos;
    logic [OFF_W-1:0]       r_off;
    logic                   r_bitv;
    t_status                r_status;
    logic                   r_ovalid;
    logic                   r_obit;
    logic [IDX_W-1:0]       r_ofound;
    t_status                r_ostatus;

    // bitmap RAM plus per-word valid flags
    logic [WORD_BITS-1:0]   r_mem [NUM_WORDS];
    logic [NUM_WORDS-1:0]   r_vbits;
    logic [WORD_BITS-1:0]   r_rdata;
    logic                   r_rvld;

    logic                   w_empty;
    logic [IDX_W-1:0]       w_span;
    logic [OFF_W-1:0]       w_last;
    logic [IDX_W-1:0]       w_off;
    logic                   w_out;
    logic [WORD_AW-1:0]     w_rd_addr;
    logic                   w_wr_en;
    logic [WORD_BITS-1:0]   w_wr_data;
    logic [WORD_BITS-1:0]   w_rword;
    logic [WORD_BITS-1:0]   w_free;
    logic                   w_hit;
    logic [BIT_W-1:0]       w_hitpos;
    logic [WORD_AW-1:0]     w_addr_inc;
    logic                   w_cfg_wr;
    logic                   w_out_free;

    // Configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_HIGHEST) ? CFG_DW'(r_hi) : CFG_DW'(r_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo <= RESET_LOWEST;
            r_hi <= RESET_HIGHEST;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                REG_LOWEST:  r_lo <= pwdata[IDX_W-1:0];
                REG_HIGHEST: r_hi <= pwdata[IDX_W-1:0];
                default:     r_lo <= r_lo;
            endcase
        end
    end

    // Range: last in-range offset, clamped to capacity
    assign w_empty = r_lo > r_hi;
    assign w_span  = r_hi - r_lo;
    assign w_last  = (w_span > LAST_CAP_OFF) ? OFF_W'(CAPACITY - 1) : w_span[OFF_W-1:0];
    assign w_off   = r_index - r_lo;
    assign w_out   = w_empty || (r_index < r_lo) || (w_off > IDX_W'(w_last));

    // Word under evaluation; words never written read as zero
    assign w_rword    = r_rvld ? r_rdata : '0;
    assign w_free     = ~w_rword & ((r_pw == r_lastw) ? r_lmask : {WORD_BITS{1'b1}});
    assign w_hit      = |w_free;
    assign w_hitpos   = lowest_set(w_free);
    assign w_addr_inc = ((CNT_W'(r_addr) + 1'b1) == r_words) ? '0 : r_addr + 1'b1;
    assign w_out_free = !r_ovalid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_CHK;
            end
            S_CHK: begin
                if (r_op == OP_FIND) n_state = w_empty ? S_RESP : S_MOD;
                else                 n_state = w_out ? S_RESP : S_ACC;
            end
            S_MOD: begin
                if (CNT_W'(r_addr) < r_words) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_pend && (w_hit || (r_left == '0))) n_state = S_RESP;
            end
            S_ACC: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_wr_en    = (r_state == S_ACC) && ((r_op == OP_SET) || (r_op == OP_CLEAR));
        w_rd_addr  = (r_state == S_CHK) ? w_off[OFF_W-1:BIT_W] : r_addr;
        w_wr_data  = (r_op == OP_SET) ? (w_rword | (WORD_BITS'(1) << r_bitpos))
                                      : (w_rword & ~(WORD_BITS'(1) << r_bitpos));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // Bitmap RAM: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_wr_en) r_mem[r_wa] <= w_wr_data;
        r_rdata <= r_mem[w_rd_addr];
        r_rvld  <= r_vbits[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)     r_vbits <= '0;
        else if (w_wr_en) r_vbits[r_wa] <= 1'b1;
    end

    // Cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)                          r_cursor <= '0;
        else if ((r_state == S_SCAN) && r_pend) r_cursor <= r_pw;
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_op    <= i_opcode;
                    r_index <= i_index;
                end
                S_CHK: begin
                    r_bitv   <= 1'b0;
                    r_off    <= '0;
                    r_status <= ST_OK;
                    r_wa     <= w_off[OFF_W-1:BIT_W];
                    r_bitpos <= w_off[BIT_W-1:0];
                    r_addr   <= r_cursor;
                    r_words  <= CNT_W'(w_last[OFF_W-1:BIT_W]) + 1'b1;
                    r_lastw  <= w_last[OFF_W-1:BIT_W];
                    r_lmask  <= {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - w_last[BIT_W-1:0]);
                    if (r_op == OP_FIND) begin
                        if (w_empty) r_status <= ST_FULL;
                    end else if (w_out) begin
                        r_status <= ST_RANGE;
                    end
                end
                S_MOD: begin
                    // fold the cursor below the words in use, one subtract a cycle
                    r_pend <= 1'b0;
                    r_left <= r_words;
                    if (CNT_W'(r_addr) >= r_words) r_addr <= r_addr - r_words[WORD_AW-1:0];
                end
                S_SCAN: begin
                    // evaluate the word read last cycle, fetch the next one
                    if (r_pend) begin
                        if (w_hit)               r_off    <= {r_pw, w_hitpos};
                        else if (r_left == '0)   r_status <= ST_FULL;
                    end
                    r_pend <= (r_left != '0);
                    if (r_left != '0) begin
                        r_pw   <= r_addr;
                        r_addr <= w_addr_inc;
                        r_left <= r_left - 1'b1;
                    end
                end
                S_ACC: begin
                    if (r_op == OP_GET) r_bitv <= w_rword[r_bitpos];
                end
                default: begin
                    r_pend <= 1'b0;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            if ((r_state == S_RESP) && w_out_free) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_RESP) && w_out_free) begin
            r_obit    <= r_bitv;
            r_ostatus <= r_status;
            r_ofound  <= ((r_op == OP_FIND) && (r_status == ST_OK)) ?
                         (r_lo + IDX_W'(r_off)) : '0;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_bit_value   = r_obit;
    assign o_found_index = r_ofound;
    assign o_status      = r_ostatus;

    // Checks
    `ASSERT_IMP(a_scan_addr, r_state == S_SCAN, CNT_W'(r_addr) < r_words, "scan address beyond words in use")
    `ASSERT_IMP(a_scan_word, (r_state == S_SCAN) && r_pend, CNT_W'(r_pw) < r_words, "evaluated word beyond words in use")
    `ASSERT_CLK(a_words, ((r_state == S_MOD) || (r_state == S_SCAN)) |-> (r_words != '0), "zero words in scan")
    `ASSERT_IMP(a_left, r_state == S_SCAN, r_left <= r_words, "scan count exceeds words in use")

endmodule

// ===== tb/bitmap_next_free_allocator_core_test.sv =====
module bitmap_next_free_allocator_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bnfa_pkg::*;

    localparam logic [CFG_AW-1:0] ADDR_LOWEST  = {REG_LOWEST, 2'b00};
    localparam logic [CFG_AW-1:0] ADDR_HIGHEST = {REG_HIGHEST, 2'b00};
    localparam int unsigned       CYCLE_LIMIT  = 600_000;
    localparam int                NUM_DIRECTED = 31;

    typedef struct packed {
        logic             bit_value;
        logic [IDX_W-1:0] found_index;
        t_status          status;
    } t_alloc_result;

    // one row of the directed part: a register write or an item
    typedef struct packed {
        logic              cfg;
        logic [CFG_AW-1:0] addr;
        t_opcode           op;
        logic [IDX_W-1:0]  value;
        logic              typed;
        t_alloc_result     want;
    } t_step;

    // clock, reset and block inputs, all known from time zero
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    t_opcode           i_opcode    = OP_GET;
    logic [IDX_W-1:0]  i_index     = '0;
    logic              i_out_ready = 1'b1;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [CFG_AW-1:0] paddr       = '0;
    logic [CFG_DW-1:0] pwdata      = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_bit_value;
    logic [IDX_W-1:0]  o_found_index;
    t_status           o_status;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    // shadow state of the allocator
    logic [WORD_BITS-1:0] shadow_bitmap [NUM_WORDS];
    int unsigned          shadow_cursor = 0;
    int unsigned          lo_bound      = RESET_LOWEST;
    int unsigned          hi_bound      = RESET_HIGHEST;

    t_alloc_result        pending_results [$];
    t_alloc_result        last_pred;
    t_alloc_result        want_r;
    int unsigned          mismatch_count = 0;
    int unsigned          cycle_count    = 0;
    int unsigned          ready_hold     = 0;
    logic                 quiet          = 1'b0;

    t_step directed_steps [NUM_DIRECTED] = '{
        // clean bitmap after reset, bounds 0..4095
        '{1'b0, ADDR_LOWEST,  OP_GET,   16'd0,     1'b1, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_GET,   16'hFFFF,  1'b1, '{1'b0, 16'd0, ST_RANGE}},
        '{1'b0, ADDR_LOWEST,  OP_GET,   16'd4096,  1'b1, '{1'b0, 16'd0, ST_RANGE}},
        '{1'b0, ADDR_LOWEST,  OP_SET,   16'd0,     1'b1, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_GET,   16'd0,     1'b1, '{1'b1, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_FIND,  16'd0,     1'b0, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_SET,   16'd4095,  1'b1, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_GET,   16'd4095,  1'b1, '{1'b1, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_CLEAR, 16'd0,     1'b1, '{1'b0, 16'd0, ST_OK}},
        // index field is a don't-care for find
        '{1'b0, ADDR_LOWEST,  OP_FIND,  16'hFFFF,  1'b0, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_CLEAR, 16'hFFFF,  1'b1, '{1'b0, 16'd0, ST_RANGE}},
        '{1'b0, ADDR_LOWEST,  OP_SET,   16'd4096,  1'b1, '{1'b0, 16'd0, ST_RANGE}},
        // four-entry range, filled up until find reports full
        '{1'b1, ADDR_LOWEST,  OP_GET,   16'd100,   1'b0, '{1'b0, 16'd0, ST_OK}},
        '{1'b1, ADDR_HIGHEST, OP_GET,   16'd103,   1'b0, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_SET,   16'd100,   1'b1, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_SET,   16'd101,   1'b1, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_SET,   16'd102,   1'b1, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_SET,   16'd103,   1'b1, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_FIND,  16'd0,     1'b1, '{1'b0, 16'd0, ST_FULL}},
        '{1'b0, ADDR_LOWEST,  OP_GET,   16'd99,    1'b1, '{1'b0, 16'd0, ST_RANGE}},
        // lowest above highest: empty range
        '{1'b1, ADDR_LOWEST,  OP_GET,   16'd200,   1'b0, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_FIND,  16'd0,     1'b1, '{1'b0, 16'd0, ST_FULL}},
        '{1'b0, ADDR_LOWEST,  OP_GET,   16'd150,   1'b1, '{1'b0, 16'd0, ST_RANGE}},
        // widest bounds, clipped by capacity; old contents kept
        '{1'b1, ADDR_LOWEST,  OP_GET,   16'd0,     1'b0, '{1'b0, 16'd0, ST_OK}},
        '{1'b1, ADDR_HIGHEST, OP_GET,   16'hFFFF,  1'b0, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_GET,   16'd4095,  1'b0, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_GET,   16'd4096,  1'b1, '{1'b0, 16'd0, ST_RANGE}},
        '{1'b0, ADDR_LOWEST,  OP_FIND,  16'd0,     1'b0, '{1'b0, 16'd0, ST_OK}},
        // single-entry range at the top of the index space
        '{1'b1, ADDR_LOWEST,  OP_GET,   16'hFFFF,  1'b0, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_GET,   16'hFFFF,  1'b0, '{1'b0, 16'd0, ST_OK}},
        '{1'b0, ADDR_LOWEST,  OP_FIND,  16'd0,     1'b0, '{1'b0, 16'd0, ST_OK}}
    };

    bitmap_next_free_allocator_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_index       (i_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_bit_value   (o_bit_value),
        .o_found_index (o_found_index),
        .o_status      (o_status),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #2 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stall bursts between runs of ready
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!quiet && i_out_ready && $urandom_range(0, 5) == 0) begin
            i_out_ready <= 1'b0;
            ready_hold  <= $urandom_range(0, 18);
        end else begin
            i_out_ready <= 1'b1;
            ready_hold  <= quiet ? 0 : $urandom_range(0, 20);
        end
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // compare each result item against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result item with nothing expected");
            end else begin
                want_r = pending_results.pop_front();
                if (o_bit_value !== want_r.bit_value)
                    report_mismatch($sformatf("bit_value got %0b want %0b",
                                              o_bit_value, want_r.bit_value));
                if (o_found_index !== want_r.found_index)
                    report_mismatch($sformatf("found_index got %0d want %0d",
                                              o_found_index, want_r.found_index));
                if (o_status !== want_r.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want_r.status));
            end
        end
    end

    // next-fit allocator behaviour on the shadow state
    function automatic t_alloc_result apply_alloc_op(input t_opcode op,
                                                     input logic [IDX_W-1:0] idx);
        t_alloc_result r;
        int unsigned   last;
        int unsigned   words;
        int unsigned   first_word;
        int unsigned   w;
        int unsigned   o;
        int unsigned   off;
        bit            hit;
        r   = '{1'b0, '0, ST_OK};
        hit = 1'b0;
        // empty range: nothing in range, cursor untouched
        if (lo_bound > hi_bound) begin
            r.status = (op == OP_FIND) ? ST_FULL : ST_RANGE;
            return r;
        end
        last = hi_bound - lo_bound;
        if (last > CAPACITY - 1) last = CAPACITY - 1;
        if (op == OP_FIND) begin
            words      = last / WORD_BITS + 1;
            first_word = shadow_cursor % words;
            for (int i = 0; i < words && !hit; i++) begin
                w             = (first_word + i) % words;
                shadow_cursor = w;
                if (&shadow_bitmap[w]) continue;
                for (int j = 0; j < WORD_BITS; j++) begin
                    o = w * WORD_BITS + j;
                    if (o > last) break;
                    if (!shadow_bitmap[w][j]) begin
                        r.found_index = IDX_W'(lo_bound + o);
                        hit           = 1'b1;
                        break;
                    end
                end
            end
            if (!hit) r.status = ST_FULL;
        end else if (idx < lo_bound || idx - lo_bound > last) begin
            r.status = ST_RANGE;
        end else begin
            off = idx - lo_bound;
            w   = off / WORD_BITS;
            case (op)
                OP_GET:  r.bit_value = shadow_bitmap[w][off % WORD_BITS];
                OP_SET:  shadow_bitmap[w][off % WORD_BITS] = 1'b1;
                default: shadow_bitmap[w][off % WORD_BITS] = 1'b0;
            endcase
        end
        return r;
    endfunction

    // mostly in range, sometimes on or just past the bounds
    function automatic logic [IDX_W-1:0] pick_index();
        int unsigned span;
        if (lo_bound > hi_bound || $urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 4))
                0:       return IDX_W'(lo_bound - 1);
                1:       return IDX_W'(hi_bound + 1);
                2:       return IDX_W'(lo_bound + CAPACITY);
                3:       return IDX_W'(hi_bound);
                default: return IDX_W'($urandom);
            endcase
        end
        span = hi_bound - lo_bound;
        if (span > CAPACITY - 1) span = CAPACITY - 1;
        return IDX_W'(lo_bound + $urandom_range(0, span));
    endfunction

    // present one item, wait for it to be taken, then log its expectation
    task automatic send_item(input t_opcode op, input logic [IDX_W-1:0] idx,
                             input logic typed, input t_alloc_result typed_res);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_index    <= idx;
        do @(posedge i_clk); while (!o_in_ready);
        last_pred = apply_alloc_op(op, idx);
        pending_results.push_back(typed ? typed_res : last_pred);
    endtask

    // let the block go idle before touching the bounds
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [IDX_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= CFG_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_LOWEST) lo_bound = value;
        else hi_bound = value;
        @(posedge i_clk);
    endtask

    initial begin
        t_alloc_result none;
        int unsigned   lo;
        int unsigned   hi;
        int unsigned   n;
        int unsigned   roll;
        none = '{1'b0, '0, ST_OK};
        for (int k = 0; k < NUM_WORDS; k++) shadow_bitmap[k] = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int k = 0; k < NUM_DIRECTED; k++) begin
            if (directed_steps[k].cfg) begin
                drain_results();
                write_reg(directed_steps[k].addr, directed_steps[k].value);
            end else begin
                send_item(directed_steps[k].op, directed_steps[k].value,
                          directed_steps[k].typed, directed_steps[k].want);
            end
        end

        // random phases, one bound setting each; the last one without idling
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin lo = 0;     hi = 4095;  n = 100; end
                1: begin lo = 0;     hi = 63;    n = 30;  end
                2: begin
                    lo = $urandom_range(0, 65000);
                    hi = lo + $urandom_range(0, 40);
                    n  = 25;
                end
                3: begin lo = 0;     hi = 65535; n = 20;  end
                4: begin lo = 65535; hi = 65535; n = 15;  end
                5: begin lo = 65535; hi = 0;     n = 10;  end
                6: begin
                    lo = $urandom_range(0, 65535);
                    hi = $urandom_range(0, 65535);
                    n  = 25;
                end
                default: begin
                    lo = $urandom_range(0, 1000);
                    hi = lo + $urandom_range(0, 3000);
                    n  = 45;
                end
            endcase
            if (p == 7) quiet <= 1'b1;
            drain_results();
            write_reg(ADDR_LOWEST, IDX_W'(lo));
            write_reg(ADDR_HIGHEST, IDX_W'(hi));
            for (int k = 0; k < n; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    // allocate: find a free index, then claim it
                    send_item(OP_FIND, IDX_W'($urandom), 1'b0, none);
                    if (last_pred.status == ST_OK)
                        send_item(OP_SET, last_pred.found_index, 1'b0, none);
                end else if (roll < 60) begin
                    send_item(OP_CLEAR, pick_index(), 1'b0, none);
                end else if (roll < 75) begin
                    send_item(OP_GET, pick_index(), 1'b0, none);
                end else begin
                    send_item(t_opcode'($urandom_range(0, 3)), IDX_W'($urandom), 1'b0, none);
                end
            end
        end

        drain_results();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/bnfa_pkg.sv
src/bitmap_next_free_allocator_core.sv
tb/bitmap_next_free_allocator_core_test.sv
